[hdl/gdil_pkg.sv]
// Shared types and constants for the 3x3 grayscale dilation core.
`default_nettype none

package gdil_pkg;

    localparam int PIX_W      = 8;
    localparam int ROW_W      = 12;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 13;
    localparam int FW_W       = 11;
    localparam int FH_W       = 13;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

    localparam int FRAME_HEIGHT_RST = 480;
    localparam int FRAME_WIDTH_RST  = 1024;
    localparam int MAX_HEIGHT       = 4096;

    typedef logic [PIX_W-1:0] pix_t;

    // Per-request control that follows the pixel down the pipe
    typedef struct packed {
        logic result_en;
        logic last;
    } win_ctl_t;

endpackage

`default_nettype wire

[hdl/gdil_geom.sv]
// Frame geometry registers and raster column/row counters.
`default_nettype none

module gdil_geom #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [gdil_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [gdil_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                            accept,
    input  wire logic                            frame_start,
    output logic [$clog2(MAX_WIDTH)-1:0]         col_idx,
    output gdil_pkg::win_ctl_t                   ctl
);
    import gdil_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WUW = $clog2(MAX_WIDTH + 1);
    localparam int W_RST_LAST = ((MAX_WIDTH < FRAME_WIDTH_RST) ? MAX_WIDTH
                                                               : FRAME_WIDTH_RST) - 1;

    logic [WUW-1:0]   w_last_reg;
    logic [ROW_W-1:0] h_last_reg;
    logic [CW-1:0]    col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [CW-1:0]    col_cur;
    logic [ROW_W-1:0] row_cur;
    logic [31:0]      w_cfg, h_cfg, w_clamp, h_clamp;
    logic             col_wrap;

    // Saturate the written geometry and keep last index (size - 1)
    always_comb begin
        w_cfg = 32'(cfg_wdata[FW_W-1:0]);
        h_cfg = 32'(cfg_wdata[FH_W-1:0]);
        priority if (w_cfg < 32'd3)               w_clamp = 32'd3;
        else if (w_cfg > 32'(MAX_WIDTH))          w_clamp = 32'(MAX_WIDTH);
        else                                      w_clamp = w_cfg;
        priority if (h_cfg < 32'd3)               h_clamp = 32'd3;
        else if (h_cfg > 32'(MAX_HEIGHT))         h_clamp = 32'(MAX_HEIGHT);
        else                                      h_clamp = h_cfg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_last_reg <= WUW'(W_RST_LAST);
            h_last_reg <= ROW_W'(FRAME_HEIGHT_RST - 1);
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_FRAME_WIDTH:  w_last_reg <= WUW'(w_clamp - 32'd1);
                CFG_FRAME_HEIGHT: h_last_reg <= ROW_W'(h_clamp - 32'd1);
                default: ;
            endcase
        end
    end

    always_comb begin
        col_cur  = frame_start ? '0 : col_reg;
        row_cur  = frame_start ? '0 : row_reg;
        col_wrap = 32'(col_cur) >= 32'(w_last_reg);
        if (col_wrap) begin
            col_next = '0;
            row_next = (row_cur >= h_last_reg) ? '0 : row_cur + 1'b1;
        end else begin
            col_next = col_cur + 1'b1;
            row_next = row_cur;
        end
        col_idx       = col_cur;
        ctl.result_en = (row_cur >= ROW_W'(2)) && (32'(col_cur) >= 32'd2);
        ctl.last      = (row_cur == h_last_reg) && (32'(col_cur) == 32'(w_last_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

`default_nettype wire

[hdl/gdil_linebuf.sv]
// Two line buffers holding the previous two rows, registered read.
`default_nettype none

module gdil_linebuf #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                        aclk,
    input  wire logic                        rd_en,
    input  wire logic [$clog2(MAX_WIDTH)-1:0] rd_idx,
    input  wire logic                        wr_en,
    input  wire logic [$clog2(MAX_WIDTH)-1:0] wr_idx,
    input  wire gdil_pkg::pix_t              wr_above,
    input  wire gdil_pkg::pix_t              wr_two_above,
    output gdil_pkg::pix_t                   up1,
    output gdil_pkg::pix_t                   up2
);
    import gdil_pkg::*;

    pix_t line_above_mem     [MAX_WIDTH];
    pix_t line_two_above_mem [MAX_WIDTH];
    pix_t up1_reg, up2_reg;
    logic fwd;

    // Same column read and written in one cycle: take the write data
    assign fwd = wr_en && (rd_idx == wr_idx);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_above_mem[wr_idx]     <= wr_above;
            line_two_above_mem[wr_idx] <= wr_two_above;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (fwd) begin
                up1_reg <= wr_above;
                up2_reg <= wr_two_above;
            end else begin
                up1_reg <= line_above_mem[rd_idx];
                up2_reg <= line_two_above_mem[rd_idx];
            end
        end
    end

    assign up1 = up1_reg;
    assign up2 = up2_reg;

endmodule

`default_nettype wire

[hdl/gdil_window.sv]
// Column max, 3-column window max and output register.
`default_nettype none

module gdil_window (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               advance,
    input  wire gdil_pkg::pix_t     px,
    input  wire gdil_pkg::pix_t     up1,
    input  wire gdil_pkg::pix_t     up2,
    input  wire gdil_pkg::win_ctl_t ctl,
    input  wire logic               m_tready,
    output logic                    m_tvalid,
    output gdil_pkg::pix_t          m_pixel,
    output logic                    m_last
);
    import gdil_pkg::*;

    pix_t col_max_left_reg, col_max_mid_reg;
    pix_t col_max, upper_max, side_max, win_max;
    logic m_valid_reg;
    pix_t m_pixel_reg;
    logic m_last_reg;

    always_comb begin
        upper_max = (up1 > up2) ? up1 : up2;
        col_max   = (px > upper_max) ? px : upper_max;
        side_max  = (col_max_left_reg > col_max_mid_reg) ? col_max_left_reg
                                                         : col_max_mid_reg;
        win_max   = (col_max > side_max) ? col_max : side_max;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_max_left_reg <= '0;
            col_max_mid_reg  <= '0;
            m_valid_reg      <= 1'b0;
        end else if (advance) begin
            col_max_left_reg <= col_max_mid_reg;
            col_max_mid_reg  <= col_max;
            m_valid_reg      <= ctl.result_en;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_pixel_reg <= win_max;
            m_last_reg  <= ctl.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_pixel  = m_pixel_reg;
    assign m_last   = m_last_reg;

endmodule

`default_nettype wire

[hdl/gray_dilation_3x3_core.sv]
// 3x3 grayscale dilation (max filter) over a bordered raster pixel stream.
//
// Usage:
//   s_axis: one 8-bit pixel per request in raster order; tuser high marks
//   the first pixel of a frame and clears the column/row counters.
//   m_axis: one 3x3 window maximum per interior pixel, raster order;
//   tlast flags the result of the final interior pixel of the frame.
//   cfg: write frame_width (index 0) and frame_height (index 1) while idle;
//   values are saturated to [3, MAX_WIDTH] and [3, 4096].
// Throughput: one pixel per clock sustained while m_axis is not stalled. The line
//   buffer read for a pixel is registered in the stage after the input, and a
//   result is registered in the output stage before it shows on m_axis.
// Border pixels (first two rows of a frame, first two columns of every row) give no
//   result; their request is taken and the window state is updated.
// Reset: counters and column maxima clear, frame_width = 1024 (MAX_WIDTH if
//   smaller), frame_height = 480. Line buffers are not cleared; rows 0 and 1 of
//   every frame fill them before they feed any result.
// Stall: when m_tready is low the output register holds, the middle stage
//   holds, and s_axis_tready drops once both are full.
`default_nettype none

module gray_dilation_3x3_core #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [7:0]                      s_axis_tdata,  // [7:0] pixel_in
    input  wire logic                            s_axis_tuser,  // [0] frame_start
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [7:0]                           m_axis_tdata,  // [7:0] out_pixel
    output logic                                 m_axis_tlast,
    input  wire logic                            cfg_wr_en,
    input  wire logic [gdil_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [gdil_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import gdil_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    logic          accept, advance;
    logic [CW-1:0] col_idx;
    win_ctl_t      ctl_cur;
    logic          b_valid_reg;
    pix_t          b_px_reg;
    logic [CW-1:0] b_idx_reg;
    win_ctl_t      b_ctl_reg;
    pix_t          up1, up2;

    assign advance       = b_valid_reg && (!m_axis_tvalid || m_axis_tready);
    assign s_axis_tready = !b_valid_reg || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;

    gdil_geom #(.MAX_WIDTH(MAX_WIDTH)) u_geom (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .accept      (accept),
        .frame_start (s_axis_tuser),
        .col_idx     (col_idx),
        .ctl         (ctl_cur)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (accept) begin
            b_valid_reg <= 1'b1;
        end else if (advance) begin
            b_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            b_px_reg  <= s_axis_tdata;
            b_idx_reg <= col_idx;
            b_ctl_reg <= ctl_cur;
        end
    end

    gdil_linebuf #(.MAX_WIDTH(MAX_WIDTH)) u_linebuf (
        .aclk         (aclk),
        .rd_en        (accept),
        .rd_idx       (col_idx),
        .wr_en        (advance),
        .wr_idx       (b_idx_reg),
        .wr_above     (b_px_reg),
        .wr_two_above (up1),
        .up1          (up1),
        .up2          (up2)
    );

    gdil_window u_window (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .px       (b_px_reg),
        .up1      (up1),
        .up2      (up2),
        .ctl      (b_ctl_reg),
        .m_tready (m_axis_tready),
        .m_tvalid (m_axis_tvalid),
        .m_pixel  (m_axis_tdata),
        .m_last   (m_axis_tlast)
    );

endmodule

`default_nettype wire

[dv/gray_dilation_3x3_checker.sv]
// Window-maximum predictor and result checker for the 3x3 dilation core.
module gray_dilation_3x3_checker #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,  // [7:0] pixel_in
    input  logic                            s_axis_tuser,  // [0] frame_start
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [7:0]                      m_axis_tdata,  // [7:0] out_pixel
    input  logic                            m_axis_tlast,
    input  logic                            cfg_wr_en,
    input  logic [gdil_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [gdil_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                              mismatches,
    output int                              pending,
    output int                              results_seen
);
    import gdil_pkg::*;

    typedef struct packed {
        pix_t peak;
        logic last;
    } window_max_t;

    window_max_t     window_max_q[$];
    pix_t            prev_row [MAX_WIDTH];
    pix_t            prev2_row [MAX_WIDTH];
    pix_t            peak_col2;
    pix_t            peak_col1;
    logic [FW_W-1:0] width_reg;
    logic [FH_W-1:0] height_reg;
    logic [FW_W-1:0] x_pos;
    logic [FH_W-1:0] y_pos;
    int              err_cnt = 0;
    int              got_cnt = 0;

    initial begin
        mismatches   = 0;
        pending      = 0;
        results_seen = 0;
    end

    function automatic pix_t max_pix(input pix_t a, input pix_t b);
        return (a > b) ? a : b;
    endfunction

    // One pixel through the window model; queues a result once a full 3x3 window exists
    function automatic void predict_window_max(input pix_t px, input logic sof);
        int unsigned wu;
        int unsigned hu;
        int unsigned idx;
        pix_t        a1;
        pix_t        a2;
        pix_t        col_peak;
        window_max_t r;

        wu = (width_reg < 3) ? 3 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
        hu = (height_reg < 3) ? 3 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
        if (sof) begin
            x_pos = '0;
            y_pos = '0;
        end
        idx = (x_pos < MAX_WIDTH) ? x_pos : MAX_WIDTH - 1;

        a1 = prev_row[idx];
        a2 = prev2_row[idx];
        col_peak = max_pix(max_pix(a2, a1), px);
        prev2_row[idx] = a1;
        prev_row[idx]  = px;

        if (y_pos >= 2 && x_pos >= 2) begin
            r.peak = max_pix(max_pix(peak_col2, peak_col1), col_peak);
            r.last = (y_pos == hu - 1) && (x_pos == wu - 1);
            window_max_q.push_back(r);
        end
        peak_col2 = peak_col1;
        peak_col1 = col_peak;

        // counters past a shrunken geometry wrap on the next pixel
        if (x_pos + 1 >= wu) begin
            x_pos = '0;
            y_pos = (y_pos + 1 >= hu) ? '0 : y_pos + 1'b1;
        end else begin
            x_pos = x_pos + 1'b1;
        end
    endfunction

    always @(posedge aclk) begin
        window_max_t want;
        if (!aresetn) begin
            window_max_q.delete();
            for (int i = 0; i < MAX_WIDTH; i++) begin
                prev_row[i]  = '0;
                prev2_row[i] = '0;
            end
            peak_col2  = '0;
            peak_col1  = '0;
            x_pos      = '0;
            y_pos      = '0;
            width_reg  = FW_W'(FRAME_WIDTH_RST);
            height_reg = FH_W'(FRAME_HEIGHT_RST);
        end else begin
            if (cfg_wr_en) begin
                if (cfg_addr == CFG_FRAME_WIDTH) begin
                    width_reg = cfg_wdata[FW_W-1:0];
                end else if (cfg_addr == CFG_FRAME_HEIGHT) begin
                    height_reg = cfg_wdata[FH_W-1:0];
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                predict_window_max(s_axis_tdata, s_axis_tuser);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got_cnt++;
                if (window_max_q.size() == 0) begin
                    if (err_cnt < 10) begin
                        $display("result %0d not expected: out_pixel %0d tlast %0b",
                                 got_cnt, m_axis_tdata, m_axis_tlast);
                    end
                    err_cnt++;
                end else begin
                    want = window_max_q.pop_front();
                    if (m_axis_tdata !== want.peak || m_axis_tlast !== want.last) begin
                        if (err_cnt < 10) begin
                            $display("result %0d: expected out_pixel %0d tlast %0b, got %0d %0b",
                                     got_cnt, want.peak, want.last, m_axis_tdata, m_axis_tlast);
                        end
                        err_cnt++;
                    end
                end
            end
        end
        mismatches   <= err_cnt;
        pending      <= window_max_q.size();
        results_seen <= got_cnt;
    end

endmodule

[dv/gray_dilation_3x3_core_tb.sv]
// Testbench top for the 3x3 dilation core: clock, reset, pixel stimulus and verdict.
module gray_dilation_3x3_core_tb;
    import gdil_pkg::*;

    localparam int          MAX_W        = 1024;
    localparam int          RANDOM_ITEMS = 800;
    localparam int          LONG_STALL   = 300;
    localparam int unsigned CYCLE_LIMIT  = 3_000_000;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata  = '0;   // [7:0] pixel_in
    logic                  s_axis_tuser  = 1'b0; // [0] frame_start
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [7:0]            m_axis_tdata;         // [7:0] out_pixel
    logic                  m_axis_tlast;
    logic                  cfg_wr_en     = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr      = CFG_FRAME_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;

    int          mismatches;
    int          pending;
    int          results_seen;
    int unsigned frame_w    = FRAME_WIDTH_RST;
    int unsigned frame_h    = FRAME_HEIGHT_RST;
    int          items_sent = 0;
    int          n_geom     = 0;
    int unsigned cycle_cnt  = 0;
    logic        hold_req   = 1'b0;

    gray_dilation_3x3_core #(
        .MAX_WIDTH(MAX_W)
    ) uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata)
    );

    gray_dilation_3x3_checker #(
        .MAX_WIDTH(MAX_W)
    ) chk (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .mismatches   (mismatches),
        .pending      (pending),
        .results_seen (results_seen)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // One pixel request; returns at the edge where it was taken
    task automatic push_pixel(input pix_t pix, input logic sof, input int gap);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        s_axis_tuser  <= sof;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic send_frame(input int unsigned n_px, input logic sof, input logic burst);
        pix_t pix;
        for (int unsigned i = 0; i < n_px; i++) begin
            case ($urandom_range(0, 7))
                0:       pix = 8'h00;
                1:       pix = 8'hFF;
                default: pix = pix_t'($urandom_range(0, 255));
            endcase
            push_pixel(pix, sof && (i == 0), burst ? 0 : $urandom_range(0, 13));
        end
    endtask

    // Drain: every queued result out, then a wait for border pixels still in the pipe
    task automatic settle_idle();
        s_axis_tvalid <= 1'b0;
        repeat (2) @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic set_geometry(input logic [CFG_DATA_W-1:0] w_raw,
                                input logic [CFG_DATA_W-1:0] h_raw);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_FRAME_WIDTH;
        cfg_wdata <= w_raw;
        @(posedge aclk);
        cfg_addr  <= CFG_FRAME_HEIGHT;
        cfg_wdata <= h_raw;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        frame_w = (w_raw[FW_W-1:0] < 3) ? 3 :
                  (w_raw[FW_W-1:0] > MAX_W) ? MAX_W : w_raw[FW_W-1:0];
        frame_h = (h_raw[FH_W-1:0] < 3) ? 3 :
                  (h_raw[FH_W-1:0] > MAX_HEIGHT) ? MAX_HEIGHT : h_raw[FH_W-1:0];
        n_geom++;
    endtask

    // Small random geometry, now and then below the legal minimum; width's unused
    // upper bits get random values
    task automatic regeometry_random();
        logic [FW_W-1:0] w;
        logic [FH_W-1:0] h;
        settle_idle();
        w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
        h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
        set_geometry({2'($urandom_range(0, 3)), w}, h);
    endtask

    // Output side: random stalls, bursts with none, and one long hold-off on request
    initial begin : sink
        int   gap;
        logic hold_done;
        logic rx_burst;
        hold_done = 1'b0;
        rx_burst  = 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_req && !hold_done) begin
                gap = LONG_STALL;
                hold_done = 1'b1;
            end else begin
                gap = rx_burst ? 0 : $urandom_range(0, 13);
            end
            if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            @(posedge aclk);
            while (!m_axis_tvalid) @(posedge aclk);
        end
    end

    initial begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles, %0d results still owed", cycle_cnt, pending);
        $display("FAILED: results differ");
        $finish;
    end

    initial begin : stimulus
        int unsigned rnd_items;
        int unsigned n_px;
        int unsigned cut;
        logic        aligned;
        logic        sof;
        logic        burst;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // smallest frame, reached by saturating both registers from below;
        // brightest pixel at the last corner
        set_geometry(13'h1800, 13'h0001);
        for (int i = 0; i < 9; i++) begin
            push_pixel((i == 8) ? 8'hFF : 8'h00, i == 0, $urandom_range(0, 13));
        end
        // next frame starts by wrap, then gets cut off by a restart
        for (int i = 0; i < 4; i++) begin
            push_pixel(8'h80, 1'b0, $urandom_range(0, 13));
        end
        for (int i = 0; i < 9; i++) begin
            push_pixel((i == 0) ? 8'hFF : 8'h01, i == 0, $urandom_range(0, 13));
        end

        // all-ones geometry saturates to the widest and tallest frame; only the
        // start of its first row goes in, so no window completes
        settle_idle();
        set_geometry(13'h1FFF, 13'h1FFF);
        send_frame(40, 1'b1, 1'b0);

        // back-to-back input against a long output hold-off; its 12 columns
        // write every line buffer entry that the later, narrower frames use
        settle_idle();
        set_geometry(13'd12, 13'd8);
        hold_req <= 1'b1;
        send_frame(frame_w * frame_h, 1'b1, 1'b1);
        rnd_items = frame_w * frame_h;
        aligned   = 1'b1;

        while (rnd_items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 3) == 0) begin
                regeometry_random();
                aligned = 1'b0;
            end
            n_px  = frame_w * frame_h;
            sof   = !aligned || ($urandom_range(0, 3) != 0);
            burst = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 11))
                0: begin
                    // cut short; the next frame restarts mid-frame
                    n_px = $urandom_range(1, n_px - 1);
                    send_frame(n_px, sof, burst);
                    aligned = 1'b0;
                end
                1: begin
                    cut = $urandom_range(1, n_px - 1);
                    send_frame(cut, sof, burst);
                    regeometry_random();
                    send_frame(n_px - cut, 1'b0, burst);
                    aligned = 1'b0;
                end
                default: begin
                    send_frame(n_px, sof, burst);
                    aligned = 1'b1;
                end
            endcase
            rnd_items += n_px;
        end

        settle_idle();
        $display("Sent %0d pixels, checked %0d window maxima across %0d frame geometries,",
                 items_sent, results_seen, n_geom);
        $display("small frames up to 12 wide, saturated geometry, restarts, cut frames, stalls.");
        if (mismatches == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

[gray_dilation_3x3_core.f]
hdl/gdil_pkg.sv
hdl/gdil_geom.sv
hdl/gdil_linebuf.sv
hdl/gdil_window.sv
hdl/gray_dilation_3x3_core.sv
dv/gray_dilation_3x3_checker.sv
dv/gray_dilation_3x3_core_tb.sv
